@@ rtl/c8cfu_pkg.sv @@
// Shared types and constants for the CHIP-8 control-flow unit.
// This file depends on nothing. Every other RTL file but c8cfu_stack_ram imports it.
`default_nettype none

package c8cfu_pkg;

  localparam int unsigned AddrW = 12;

  localparam logic [AddrW-1:0] PcReset  = 12'h200;
  localparam logic [AddrW-1:0] PcStep   = 12'd2;
  localparam logic [AddrW-1:0] PcSkip   = 12'd4;
  localparam logic [15:0]      OpRet    = 16'h00EE;

  localparam logic [3:0] GrpSys  = 4'h0;
  localparam logic [3:0] GrpJp   = 4'h1;
  localparam logic [3:0] GrpCall = 4'h2;
  localparam logic [3:0] GrpSei  = 4'h3;
  localparam logic [3:0] GrpSnei = 4'h4;
  localparam logic [3:0] GrpSer  = 4'h5;
  localparam logic [3:0] GrpSner = 4'h9;
  localparam logic [3:0] GrpLdi  = 4'hA;
  localparam logic [3:0] GrpJpv0 = 4'hB;
  localparam logic [3:0] GrpRnd  = 4'hC;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnhandled = 2'd1,
    StOverflow  = 2'd2,
    StUnderflow = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  vx_value;
    logic [7:0]  vy_value;
    logic [7:0]  v0_value;
    logic [7:0]  random_byte;
  } in_req_t;

  typedef struct packed {
    logic [AddrW-1:0] next_pc;
    logic [AddrW-1:0] index_out;
    logic             reg_write;
    logic [3:0]       reg_index;
    logic [7:0]       reg_value;
    status_e          status;
  } out_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic overflow;
    logic underflow;
  } stack_op_t;

endpackage

`default_nettype wire

@@ rtl/c8cfu_stack_ram.sv @@
// Return stack storage: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none

module c8cfu_stack_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/c8cfu_exec.sv @@
// Execute stage: holds PC and I, resolves each request and registers the result.
// Depends on c8cfu_pkg.
`default_nettype none

module c8cfu_exec (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire c8cfu_pkg::in_req_t           req_i,
  input  wire c8cfu_pkg::stack_op_t         stk_i,
  input  wire logic [c8cfu_pkg::AddrW-1:0]  top_i,
  output logic                              fire_o,
  output logic                              wr_en_o,
  output logic      [c8cfu_pkg::AddrW-1:0]  wr_data_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output c8cfu_pkg::out_rsp_t               out_rsp_o
);

  import c8cfu_pkg::*;

  logic [AddrW-1:0] pc_q, pc_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_q, out_d;

  logic [AddrW-1:0] seq_pc, skip_pc, nnn;
  logic [3:0]       grp;
  logic [7:0]       kk;
  logic             vx_eq_kk, vx_eq_vy, n_zero;

  assign fire_o    = req_valid_i && (!out_valid_q || !out_stall_i);
  assign seq_pc    = pc_q + PcStep;
  assign skip_pc   = pc_q + PcSkip;
  assign grp       = req_i.opcode[15:12];
  assign nnn       = req_i.opcode[11:0];
  assign kk        = req_i.opcode[7:0];
  assign vx_eq_kk  = (req_i.vx_value == kk);
  assign vx_eq_vy  = (req_i.vx_value == req_i.vy_value);
  assign n_zero    = (req_i.opcode[3:0] == 4'd0);
  assign wr_en_o   = fire_o && stk_i.push;
  assign wr_data_o = seq_pc;

  always_comb begin
    pc_d  = seq_pc;
    idx_d = idx_q;
    out_d = '0;
    out_d.status = StOk;
    case (grp)
      GrpSys: begin
        if (req_i.opcode == OpRet) begin
          if (stk_i.underflow) begin
            pc_d = pc_q;
            out_d.status = StUnderflow;
          end else begin
            pc_d = top_i;
          end
        end else begin
          out_d.status = StUnhandled;
        end
      end
      GrpJp:   pc_d = nnn;
      GrpCall: begin
        if (stk_i.overflow) begin
          pc_d = pc_q;
          out_d.status = StOverflow;
        end else begin
          pc_d = nnn;
        end
      end
      GrpSei:  pc_d = vx_eq_kk ? skip_pc : seq_pc;
      GrpSnei: pc_d = vx_eq_kk ? seq_pc : skip_pc;
      GrpSer: begin
        if (n_zero) begin
          pc_d = vx_eq_vy ? skip_pc : seq_pc;
        end else begin
          out_d.status = StUnhandled;
        end
      end
      GrpSner: begin
        if (n_zero) begin
          pc_d = vx_eq_vy ? seq_pc : skip_pc;
        end else begin
          out_d.status = StUnhandled;
        end
      end
      GrpLdi:  idx_d = nnn;
      GrpJpv0: pc_d = nnn + {4'd0, req_i.v0_value};
      GrpRnd: begin
        out_d.reg_write = 1'b1;
        out_d.reg_index = req_i.opcode[11:8];
        out_d.reg_value = req_i.random_byte & kk;
      end
      default: out_d.status = StUnhandled;
    endcase
    out_d.next_pc   = pc_d;
    out_d.index_out = idx_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcReset;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire_o) begin
        pc_q  <= pc_d;
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

@@ rtl/chip8_control_flow_unit_core.sv @@
// Top level of the CHIP-8 control-flow unit: stack pointer, stack RAM, execute stage.
// Depends on c8cfu_pkg, c8cfu_stack_ram and c8cfu_exec.
//
// Executes one CHIP-8 control-flow, LD I or RND instruction per request and returns one
// result per request: next PC, I, an optional register write from RND, and a status
// code. A new request can be taken every cycle while the output is not stalled. The
// request is registered into the execute stage, and its result is loaded into the
// output register when the execute stage fires. A stalled output holds the request in
// the execute stage and stalls the input in the same cycle. The return stack RAM has a
// single registered read port: the stack pointer moves at acceptance, the top entry is
// read then, and a CALL still in the execute stage is forwarded to a RET right behind
// it. The stack needs no clearing after reset; only pushed entries are ever popped.
`default_nettype none

module chip8_control_flow_unit_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire c8cfu_pkg::in_req_t  in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output c8cfu_pkg::out_rsp_t      out_rsp_o
);

  import c8cfu_pkg::*;

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam logic [SpW-1:0] SpFull = SpW'(STACK_DEPTH);

  logic [SpW-1:0]   sp_q, sp_d;
  logic             s2_valid_q, s2_valid_d;
  in_req_t          s2_req_q;
  stack_op_t        s2_stk_q, stk_d;
  logic [AW-1:0]    s2_waddr_q;
  logic             fwd_hit_q;
  logic [AddrW-1:0] fwd_data_q;

  logic             in_accept, s2_fire;
  logic             is_ret, is_call;
  logic [AW-1:0]    raddr;
  logic [SpW-1:0]   sp_dec;
  logic             wr_en;
  logic [AddrW-1:0] wr_data, rdata, top_val;

  assign in_stall_o = s2_valid_q && !s2_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_ret  = (in_req_i.opcode == OpRet);
  assign is_call = (in_req_i.opcode[15:12] == GrpCall);
  assign sp_dec  = sp_q - SpW'(1);
  assign raddr   = sp_dec[AW-1:0];

  always_comb begin
    stk_d.push      = is_call && (sp_q < SpFull);
    stk_d.overflow  = is_call && !(sp_q < SpFull);
    stk_d.pop       = is_ret && (sp_q != '0);
    stk_d.underflow = is_ret && (sp_q == '0);
    sp_d = sp_q;
    if (stk_d.push) begin
      sp_d = sp_q + SpW'(1);
    end else if (stk_d.pop) begin
      sp_d = sp_dec;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (in_accept) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q       <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (in_accept) begin
        sp_q <= sp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_req_q   <= in_req_i;
      s2_stk_q   <= stk_d;
      s2_waddr_q <= sp_q[AW-1:0];
      fwd_hit_q  <= wr_en && (s2_waddr_q == raddr);
      fwd_data_q <= wr_data;
    end
  end

  c8cfu_stack_ram #(
    .Depth (STACK_DEPTH),
    .AW    (AW),
    .DW    (AddrW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s2_waddr_q),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign top_val = fwd_hit_q ? fwd_data_q : rdata;

  c8cfu_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s2_valid_q),
    .req_i       (s2_req_q),
    .stk_i       (s2_stk_q),
    .top_i       (top_val),
    .fire_o      (s2_fire),
    .wr_en_o     (wr_en),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpFull)
    else $error("stack pointer beyond depth");

  a_push_moves_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && stk_d.push |=> sp_q == $past(sp_q) + SpW'(1))
    else $error("push did not advance stack pointer");

  a_write_only_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s2_valid_q && s2_stk_q.push && !s2_stk_q.overflow)
    else $error("stack write without a valid push");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> out_valid_o)
    else $error("executed request produced no result");

endmodule

`default_nettype wire
